// ===== rtl/blat_pkg.sv =====
// Shared types, constants and operation codes of the binary-lifting ancestor table.
package blat_pkg;

	// Fixed width of every node, step and depth field.
	localparam int FIELD_W = 10;

	// Default sizing of the table.
	localparam int NODES_DEF  = 1024;
	localparam int LEVELS_DEF = 10;

	// Depths saturate at the largest field value.
	localparam logic [FIELD_W-1:0] DEPTH_MAX = '1;

	// Operation codes carried in the kind field.
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LCA    = 2'd1;
	localparam logic [1:0] KIND_KTH    = 2'd2;

	// Request beat.
	typedef struct packed {
		logic [1:0]         kind;
		logic [FIELD_W-1:0] node_a;
		logic [FIELD_W-1:0] node_b;
		logic [FIELD_W-1:0] steps;
	} req_t;

	// Response beat.
	typedef struct packed {
		logic [FIELD_W-1:0] result_node;
		logic [FIELD_W-1:0] result_depth;
	} rsp_t;

endpackage

// ===== rtl/blat_if.sv =====
// Valid/ready stream channel carrying one payload per beat.
interface blat_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/blat_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module blat_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; a read sees writes of earlier cycles.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/binary_lifting_ancestor_table_top.sv =====
// Binary-lifting ancestor table: node insert, k-th ancestor and lowest common ancestor.
//
//   channel | dir | beat contents                         | accepted when
//   --------+-----+---------------------------------------+---------------------------
//   req     | in  | kind, node_a, node_b, steps           | req.valid && req.ready
//   rsp     | out | result_node, result_depth             | rsp.valid && rsp.ready
//
// One item at a time is worked on by a sequencer over two single-port-read RAMs
// (ancestors and depths); every table read goes through a registered RAM read port.
// req.ready returns in the cycle after the result is loaded into the output register.
// When NODES is below 1024 each item first has its node numbers reduced modulo NODES.
// Reset clears only the sequencer and the output valid; table contents are undefined.
// req.ready is high only while the sequencer is idle; a finished result waits in the
// output register, and a new request is taken while that result is still unclaimed.
module binary_lifting_ancestor_table_top #(
	parameter int NODES  = blat_pkg::NODES_DEF,
	parameter int LEVELS = blat_pkg::LEVELS_DEF
) (
	input logic   clk,
	input logic   arst_n,
	blat_if.sink   req,
	blat_if.source rsp
);
	import blat_pkg::*;

	// Sizing derived from the parameters.
	localparam int NODE_SPAN = 1 << FIELD_W;
	localparam int NODE_CNT  = (NODES < NODE_SPAN) ? NODES : NODE_SPAN;
	localparam int NODE_W    = $clog2(NODE_CNT);
	localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int ANC_AW    = NODE_W + LVL_W;
	localparam int WCNT_W    = $clog2(FIELD_W + 1);
	localparam bit NEED_WRAP = (NODES < NODE_SPAN);
	localparam logic [NODE_W:0]   NODE_CNT_C = NODE_CNT[NODE_W:0];
	localparam logic [LVL_W-1:0]  LVL_TOP    = LVL_W'(LEVELS - 1);
	localparam logic [WCNT_W-1:0] WRAP_STEPS = WCNT_W'(FIELD_W);

	// Sequencer states.
	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_WRAP    = 5'd1;
	localparam logic [4:0] S_DISP    = 5'd2;
	localparam logic [4:0] S_INS_DEP = 5'd3;
	localparam logic [4:0] S_INS_RD  = 5'd4;
	localparam logic [4:0] S_INS_WR  = 5'd5;
	localparam logic [4:0] S_KTH_D   = 5'd6;
	localparam logic [4:0] S_LCA_DA  = 5'd7;
	localparam logic [4:0] S_LCA_DB  = 5'd8;
	localparam logic [4:0] S_CLB     = 5'd9;
	localparam logic [4:0] S_CLB_W   = 5'd10;
	localparam logic [4:0] S_LCA_EQ  = 5'd11;
	localparam logic [4:0] S_DSC_A   = 5'd12;
	localparam logic [4:0] S_DSC_B   = 5'd13;
	localparam logic [4:0] S_DSC_C   = 5'd14;
	localparam logic [4:0] S_LCA_P   = 5'd15;
	localparam logic [4:0] S_LCA_R   = 5'd16;
	localparam logic [4:0] S_FIN     = 5'd17;
	localparam logic [4:0] S_FIN_W   = 5'd18;

	logic [4:0]         state_q;
	logic               out_valid_q;
	logic [1:0]         kind_q;
	logic [FIELD_W-1:0] ra_q;
	logic [FIELD_W-1:0] rb_q;
	logic [FIELD_W-1:0] k_raw_q;
	logic [WCNT_W-1:0]  wrap_cnt_q;
	logic [NODE_W-1:0]  a_q;
	logic [NODE_W-1:0]  b_q;
	logic [NODE_W-1:0]  pa_q;
	logic [NODE_W-1:0]  res_node_q;
	logic [FIELD_W-1:0] da_q;
	logic [LEVELS-1:0]  k_q;
	logic [LVL_W-1:0]   lvl_q;
	logic [NODE_W-1:0]  out_node_q;
	logic [FIELD_W-1:0] out_depth_q;

	// RAM ports.
	logic               anc_we;
	logic [ANC_AW-1:0]  anc_wa;
	logic [NODE_W-1:0]  anc_wd;
	logic [ANC_AW-1:0]  anc_ra;
	logic [NODE_W-1:0]  anc_rd;
	logic               dep_we;
	logic [NODE_W-1:0]  dep_wa;
	logic [FIELD_W-1:0] dep_wd;
	logic [NODE_W-1:0]  dep_ra;
	logic [FIELD_W-1:0] dep_rd;

	// Combinational arithmetic results.
	logic [NODE_W:0]    wrap_ta;
	logic [NODE_W:0]    wrap_tb;
	logic [FIELD_W-1:0] ins_depth;
	logic [FIELD_W-1:0] kth_steps;
	logic [FIELD_W-1:0] depth_diff;
	logic               req_fire;
	logic               out_load;

	assign req_fire = req.valid && req.ready;
	assign out_load = (state_q == S_FIN_W) && (!out_valid_q || rsp.ready);

	assign req.ready           = (state_q == S_IDLE);
	assign rsp.valid           = out_valid_q;
	assign rsp.payload.result_node  = FIELD_W'(out_node_q);
	assign rsp.payload.result_depth = out_depth_q;

	// One restoring step of the modulo-NODES reduction for both node numbers.
	always_comb begin
		wrap_ta = {a_q, ra_q[FIELD_W-1]};
		wrap_tb = {b_q, rb_q[FIELD_W-1]};
		if (wrap_ta >= NODE_CNT_C) begin
			wrap_ta = wrap_ta - NODE_CNT_C;
		end
		if (wrap_tb >= NODE_CNT_C) begin
			wrap_tb = wrap_tb - NODE_CNT_C;
		end
	end

	// Depth arithmetic: saturating increment, clamped step count and depth difference.
	assign ins_depth  = (dep_rd == DEPTH_MAX) ? DEPTH_MAX : dep_rd + 1'b1;
	assign kth_steps  = (k_raw_q > dep_rd) ? dep_rd : k_raw_q;
	assign depth_diff = (da_q > dep_rd) ? da_q - dep_rd : dep_rd - da_q;

	// RAM addressing and write strobes for each state.
	always_comb begin
		anc_we = 1'b0;
		anc_wa = {a_q, lvl_q};
		anc_wd = b_q;
		anc_ra = {b_q, lvl_q};
		dep_we = 1'b0;
		dep_wa = a_q;
		dep_wd = '0;
		dep_ra = res_node_q;
		case (state_q)
			S_DISP: begin
				if (kind_q == KIND_INSERT) begin
					anc_we = 1'b1;
					anc_wa = {a_q, {LVL_W{1'b0}}};
					if (a_q == b_q) begin
						dep_we = 1'b1;
					end else begin
						dep_ra = b_q;
					end
				end else begin
					dep_ra = a_q;
				end
			end
			S_INS_DEP: begin
				dep_we = 1'b1;
				dep_wd = ins_depth;
			end
			S_INS_RD: begin
				anc_ra = {b_q, lvl_q - 1'b1};
			end
			S_INS_WR: begin
				anc_we = 1'b1;
				anc_wd = anc_rd;
			end
			S_LCA_DA: begin
				dep_ra = b_q;
			end
			S_DSC_A: begin
				anc_ra = {a_q, lvl_q};
			end
			S_LCA_P: begin
				anc_ra = {a_q, {LVL_W{1'b0}}};
			end
			default: begin
			end
		endcase
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire && req.payload.kind inside {KIND_INSERT, KIND_LCA, KIND_KTH}) begin
						state_q <= NEED_WRAP ? S_WRAP : S_DISP;
					end
				end
				S_WRAP: begin
					if (wrap_cnt_q == WCNT_W'(1)) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (kind_q)
						KIND_INSERT: begin
							if (a_q != b_q) begin
								state_q <= S_INS_DEP;
							end else begin
								state_q <= (LEVELS > 1) ? S_INS_RD : S_FIN;
							end
						end
						KIND_LCA: state_q <= S_LCA_DA;
						default:  state_q <= S_KTH_D;
					endcase
				end
				S_INS_DEP: state_q <= (LEVELS > 1) ? S_INS_RD : S_FIN;
				S_INS_RD:  state_q <= S_INS_WR;
				S_INS_WR:  state_q <= (lvl_q == LVL_TOP) ? S_FIN : S_INS_RD;
				S_KTH_D:   state_q <= S_CLB;
				S_LCA_DA:  state_q <= S_LCA_DB;
				S_LCA_DB:  state_q <= S_CLB;
				S_CLB: begin
					if (k_q == '0) begin
						state_q <= (kind_q == KIND_KTH) ? S_FIN : S_LCA_EQ;
					end else if (k_q[0]) begin
						state_q <= S_CLB_W;
					end
				end
				S_CLB_W:  state_q <= S_CLB;
				S_LCA_EQ: state_q <= (a_q == b_q) ? S_FIN : S_DSC_A;
				S_DSC_A:  state_q <= S_DSC_B;
				S_DSC_B:  state_q <= S_DSC_C;
				S_DSC_C:  state_q <= (lvl_q == '0) ? S_LCA_P : S_DSC_A;
				S_LCA_P:  state_q <= S_LCA_R;
				S_LCA_R:  state_q <= S_FIN;
				S_FIN:    state_q <= S_FIN_W;
				S_FIN_W: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q     <= req.payload.kind;
				ra_q       <= req.payload.node_a;
				rb_q       <= req.payload.node_b;
				k_raw_q    <= req.payload.steps;
				wrap_cnt_q <= WRAP_STEPS;
				a_q        <= NEED_WRAP ? '0 : req.payload.node_a[NODE_W-1:0];
				b_q        <= NEED_WRAP ? '0 : req.payload.node_b[NODE_W-1:0];
			end
			S_WRAP: begin
				a_q        <= wrap_ta[NODE_W-1:0];
				b_q        <= wrap_tb[NODE_W-1:0];
				ra_q       <= ra_q << 1;
				rb_q       <= rb_q << 1;
				wrap_cnt_q <= wrap_cnt_q - 1'b1;
			end
			S_DISP: begin
				lvl_q      <= LVL_W'(1);
				res_node_q <= a_q;
			end
			S_INS_WR: begin
				b_q   <= anc_rd;
				lvl_q <= lvl_q + 1'b1;
			end
			S_KTH_D: begin
				k_q   <= LEVELS'(kth_steps);
				b_q   <= a_q;
				lvl_q <= '0;
			end
			S_LCA_DA: begin
				da_q <= dep_rd;
			end
			S_LCA_DB: begin
				// Keep the shallower node in a_q and climb the deeper one.
				if (da_q > dep_rd) begin
					a_q <= b_q;
					b_q <= a_q;
				end
				k_q   <= LEVELS'(depth_diff);
				lvl_q <= '0;
			end
			S_CLB: begin
				if (k_q == '0) begin
					res_node_q <= b_q;
				end else if (!k_q[0]) begin
					k_q   <= k_q >> 1;
					lvl_q <= lvl_q + 1'b1;
				end
			end
			S_CLB_W: begin
				b_q   <= anc_rd;
				k_q   <= k_q >> 1;
				lvl_q <= lvl_q + 1'b1;
			end
			S_LCA_EQ: begin
				res_node_q <= a_q;
				lvl_q      <= LVL_TOP;
			end
			S_DSC_B: begin
				pa_q <= anc_rd;
			end
			S_DSC_C: begin
				// Lift both nodes together while their ancestors still differ.
				if (pa_q != anc_rd) begin
					a_q <= pa_q;
					b_q <= anc_rd;
				end
				lvl_q <= lvl_q - 1'b1;
			end
			S_LCA_R: begin
				res_node_q <= anc_rd;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_node_q  <= res_node_q;
			out_depth_q <= dep_rd;
		end
	end

	// Ancestor table: entry {node, level} holds the ancestor at distance 2**level.
	blat_ram #(
		.WIDTH (NODE_W),
		.DEPTH (1 << ANC_AW)
	) u_anc_ram (
		.clk   (clk),
		.we    (anc_we),
		.waddr (anc_wa),
		.wdata (anc_wd),
		.raddr (anc_ra),
		.rdata (anc_rd)
	);

	// Depth table: one depth per node.
	blat_ram #(
		.WIDTH (FIELD_W),
		.DEPTH (NODE_CNT)
	) u_dep_ram (
		.clk   (clk),
		.we    (dep_we),
		.waddr (dep_wa),
		.wdata (dep_wd),
		.raddr (dep_ra),
		.rdata (dep_rd)
	);
endmodule
